[src/tpv_pkg.sv]
// tpv_pkg: shared constants, action codes and transaction types for the
// triangular pv table; no dependencies
package tpv_pkg;

  localparam int MAX_PLY      = 62;
  localparam int ROWS         = 64;
  localparam int ROW_BITS     = $clog2(ROWS);
  localparam int LEN_BITS     = ROW_BITS + 1;
  localparam int MOVE_BITS    = 16;
  localparam int PV_DEPTH     = ROWS * ROWS;

  localparam logic [2:0] ACT_UPDATE     = 3'd0;
  localparam logic [2:0] ACT_CLEAR      = 3'd1;
  localparam logic [2:0] ACT_OVERWRITE  = 3'd2;
  localparam logic [2:0] ACT_READ       = 3'd3;
  localparam logic [2:0] ACT_START_NODE = 3'd4;

  typedef struct packed {
    logic [2:0]           action;
    logic [ROW_BITS-1:0]  ply;
    logic [MOVE_BITS-1:0] move;
  } item_t;

  typedef struct packed {
    logic [MOVE_BITS-1:0] line_move;
    logic [ROW_BITS-1:0]  position;
    logic                 last;
    logic                 line_empty;
    logic [MOVE_BITS-1:0] best_move;
    logic [MOVE_BITS-1:0] ponder_move;
    logic [LEN_BITS-1:0]  root_length;
  } result_t;

  typedef struct packed {
    logic load;
    logic len_rd;
    logic head;
    logic copy;
    logic clr;
    logic ovr0;
    logic ovr1;
    logic snode;
    logic rd_step;
    logic emit;
  } tpv_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       ply_ok;
    logic       start_ok;
    logic       root_empty;
    logic       more;
    logic       pend;
  } tpv_stat_t;

endpackage

[src/tpv_ram.sv]
// tpv_ram: generic simple dual-port ram, one write and one registered read
// port; no dependencies
module tpv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/tpv_datapath.sv]
// tpv_datapath: pv row memory, row length memory with valid bits, root
// registers, copy/read cursor and result register; uses tpv_pkg, tpv_ram
module tpv_datapath import tpv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  item_t     item,
  input  tpv_cmd_t  cmd,
  output tpv_stat_t stat,
  output logic      done,
  output result_t   result
);

  item_t                 item_q;
  logic [ROW_BITS-1:0]   child;
  logic [LEN_BITS-1:0]   cur;
  logic [LEN_BITS-1:0]   lim;
  logic [ROW_BITS-1:0]   pcol;
  logic                  pend;
  logic                  lv_q;
  logic [ROWS-1:0]       lvalid;
  logic [LEN_BITS-1:0]   root_len;
  logic [MOVE_BITS-1:0]  best;
  logic [MOVE_BITS-1:0]  ponder;
  logic                  is_read;
  logic                  more;
  logic                  ply_zero;

  logic                  len_we;
  logic [ROW_BITS-1:0]   len_waddr;
  logic [LEN_BITS-1:0]   len_wdata;
  logic [LEN_BITS-1:0]   len_rdata;
  logic [LEN_BITS-1:0]   child_len;

  logic                  pv_we;
  logic [2*ROW_BITS-1:0] pv_waddr;
  logic [MOVE_BITS-1:0]  pv_wdata;
  logic [2*ROW_BITS-1:0] pv_raddr;
  logic [MOVE_BITS-1:0]  pv_rdata;

  assign child     = item_q.ply + ROW_BITS'(1);
  assign is_read   = (item_q.action == ACT_READ);
  assign ply_zero  = (item_q.ply == '0);
  assign more      = cur < (is_read ? root_len : lim);
  assign child_len = lv_q ? len_rdata : '0;

  assign stat.action     = item_q.action;
  assign stat.ply_ok     = item_q.ply <= ROW_BITS'(MAX_PLY);
  assign stat.start_ok   = {1'b0, item_q.ply} <= LEN_BITS'(MAX_PLY + 1);
  assign stat.root_empty = (root_len == '0);
  assign stat.more       = more;
  assign stat.pend       = pend;

  // row lengths
  assign len_we    = cmd.head | cmd.snode;
  assign len_waddr = item_q.ply;
  assign len_wdata = cmd.head ? child_len : {1'b0, item_q.ply};

  tpv_ram #(.WIDTH(LEN_BITS), .DEPTH(ROWS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (child),
    .rdata (len_rdata)
  );

  // pv rows, address is {row, column}
  always_comb begin
    pv_we    = 1'b0;
    pv_waddr = {item_q.ply, item_q.ply};
    pv_wdata = item_q.move;
    if (cmd.head) begin
      pv_we = 1'b1;
    end else if (cmd.copy && pend) begin
      pv_we    = 1'b1;
      pv_waddr = {item_q.ply, pcol};
      pv_wdata = pv_rdata;
    end else if (cmd.ovr0) begin
      pv_we    = 1'b1;
      pv_waddr = '0;
    end else if (cmd.ovr1) begin
      pv_we    = 1'b1;
      pv_waddr = {ROW_BITS'(0), ROW_BITS'(1)};
      pv_wdata = '0;
    end
  end

  assign pv_raddr = is_read ? {ROW_BITS'(0), cur[ROW_BITS-1:0]}
                            : {child, cur[ROW_BITS-1:0]};

  tpv_ram #(.WIDTH(MOVE_BITS), .DEPTH(PV_DEPTH)) u_pv_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (pv_raddr),
    .rdata (pv_rdata)
  );

  // architectural and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid   <= '0;
      root_len <= '0;
      best     <= '0;
      ponder   <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= cmd.emit | (cmd.rd_step & pend);
      if (cmd.copy || cmd.rd_step) begin
        pend <= more;
      end
      if (cmd.head) begin
        lvalid[item_q.ply] <= 1'b1;
        if (ply_zero) begin
          best     <= item_q.move;
          root_len <= child_len;
        end
      end
      if (cmd.copy && pend && ply_zero && pcol == ROW_BITS'(1)) begin
        ponder <= pv_rdata;
      end
      if (cmd.ovr0) begin
        best <= item_q.move;
      end
      if (cmd.ovr1) begin
        ponder <= '0;
      end
      if (cmd.snode) begin
        lvalid[item_q.ply] <= 1'b1;
        if (ply_zero) begin
          root_len <= '0;
        end
      end
      if (cmd.clr) begin
        lvalid   <= '0;
        root_len <= '0;
        best     <= '0;
        ponder   <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
      cur    <= '0;
    end
    if (cmd.len_rd) begin
      lv_q <= lvalid[child];
    end
    if (cmd.head) begin
      lim <= child_len;
      cur <= {1'b0, child};
    end
    if ((cmd.copy || cmd.rd_step) && more) begin
      cur  <= cur + LEN_BITS'(1);
      pcol <= cur[ROW_BITS-1:0];
    end
    if (cmd.rd_step && pend) begin
      result.line_move   <= pv_rdata;
      result.position    <= pcol;
      result.last        <= (LEN_BITS'(pcol) + LEN_BITS'(1)) == root_len;
      result.line_empty  <= 1'b0;
      result.best_move   <= best;
      result.ponder_move <= ponder;
      result.root_length <= root_len;
    end else if (cmd.emit) begin
      result.line_move   <= '0;
      result.position    <= '0;
      result.last        <= 1'b1;
      result.line_empty  <= is_read;
      result.best_move   <= best;
      result.ponder_move <= ponder;
      result.root_length <= root_len;
    end
  end

`ifndef NO_ASSERTIONS
  a_copy_col: assert property (@(posedge clk) disable iff (rst)
    cmd.copy && pend |-> pcol > item_q.ply)
    else $error("copy writes at or left of the diagonal");

  a_line_contig: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |=> done)
    else $error("gap inside root line read");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    done && result.line_empty |-> result.last && result.root_length == '0)
    else $error("empty line result inconsistent");

  a_root_len: assert property (@(posedge clk) disable iff (rst)
    done |-> result.root_length < LEN_BITS'(ROWS))
    else $error("root length out of range");
`endif

endmodule

[src/tpv_ctrl.sv]
// tpv_ctrl: sequencing state machine for decode, update copy, overwrite,
// line read and response; uses tpv_pkg
module tpv_ctrl import tpv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  tpv_stat_t stat,
  output tpv_cmd_t  cmd,
  output logic      busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_HEAD   = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_OVR1   = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.action)
          ACT_UPDATE: begin
            if (stat.ply_ok) begin
              cmd.len_rd = 1'b1;
              state_next = S_HEAD;
            end else begin
              state_next = S_RESP;
            end
          end
          ACT_CLEAR: begin
            cmd.clr    = 1'b1;
            state_next = S_RESP;
          end
          ACT_OVERWRITE: begin
            cmd.ovr0   = 1'b1;
            state_next = S_OVR1;
          end
          ACT_READ: begin
            state_next = stat.root_empty ? S_RESP : S_READ;
          end
          ACT_START_NODE: begin
            cmd.snode  = stat.start_ok;
            state_next = S_RESP;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_HEAD: begin
        cmd.head   = 1'b1;
        state_next = S_COPY;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (!stat.more && !stat.pend) begin
          state_next = S_RESP;
        end
      end
      S_OVR1: begin
        cmd.ovr1   = 1'b1;
        state_next = S_RESP;
      end
      S_READ: begin
        cmd.rd_step = 1'b1;
        if (!stat.more && !stat.pend) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef NO_ASSERTIONS
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without an accepted transaction");
`endif

endmodule

[src/triangular_pv_table.sv]
// triangular_pv_table: top level of the triangular pv table
// depends on tpv_pkg, tpv_ctrl, tpv_datapath (and tpv_ram below it)
//
//   channel  signals          accepted when
//   item     start, item      start && !busy at a rising edge
//   result   done, result     done high, one cycle per result
//
// an update writes the head move and then pulls the child row entries (up to 62,
// one per cycle through the pv ram read port) before its result; a read gives
// one result per line entry, or one empty result; other actions give one result.
// busy is high through the final result of a non-empty read and is already
// low when the single result of any other transaction appears.
// reset clears lengths and root registers at once; no clearing pass.
// results cannot be stalled; they leave the output register in order.
module triangular_pv_table import tpv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  tpv_cmd_t  cmd;
  tpv_stat_t stat;

  tpv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tpv_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule
